// File: rtl/fdd_pkg.sv
// Shared types, codes and constants for the FAT directory entry decoder.
// No dependencies; the decoder, entry store and sequencer import this package.
package fdd_pkg;

  localparam int unsigned ENTRY_LEN = 32;
  localparam int unsigned ADDR_W    = 5;

  // Result kinds
  localparam logic [1:0] KIND_LFN   = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam int unsigned ATTR_DIR_BIT = 4;

  // Entry byte offsets
  localparam logic [ADDR_W-1:0] OFS_ATTR    = 5'h0B;
  localparam logic [ADDR_W-1:0] OFS_CLUS_HI = 5'h14;
  localparam logic [ADDR_W-1:0] OFS_CLUS_LO = 5'h1A;
  localparam logic [ADDR_W-1:0] OFS_SIZE    = 5'h1C;
  localparam logic [ADDR_W-1:0] OFS_EXT     = 5'h08;

  // Long-name segments
  localparam logic [4:0] SEG_RAW_LAST = 5'd20;
  localparam logic [7:0] LFN_CHARS    = 8'd13;
  localparam logic [3:0] LFN_LAST_K   = 4'd12;
  localparam logic [3:0] LFN_TAIL_K   = 4'd7;

  typedef struct packed {
    logic [7:0]  first;
    logic [7:0]  attr;
    logic [31:0] cluster;
    logic [31:0] size;
    logic [10:0] space_mask;  // name bytes 0..10 equal to a space
  } entry_info_t;

  typedef struct packed {
    logic valid;
    logic eod;   // end-of-directory marker rather than a full entry
  } go_t;

  // Byte offset of long-name character k
  function automatic logic [ADDR_W-1:0] lfn_offset(input logic [3:0] k);
    logic [ADDR_W-1:0] ofs;
    unique case (k)
      4'd0:    ofs = 5'h01;
      4'd1:    ofs = 5'h03;
      4'd2:    ofs = 5'h05;
      4'd3:    ofs = 5'h07;
      4'd4:    ofs = 5'h09;
      4'd5:    ofs = 5'h0E;
      4'd6:    ofs = 5'h10;
      4'd7:    ofs = 5'h12;
      4'd8:    ofs = 5'h14;
      4'd9:    ofs = 5'h16;
      4'd10:   ofs = 5'h18;
      4'd11:   ofs = 5'h1C;
      4'd12:   ofs = 5'h1E;
      default: ofs = 5'h00;
    endcase
    return ofs;
  endfunction

  // Length of the 8-byte name with trailing spaces dropped
  function automatic logic [3:0] name_len(input logic [7:0] sp);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (!sp[i]) len = 4'(i + 1);
    end
    return len;
  endfunction

  // Length of the 3-byte extension with trailing spaces dropped
  function automatic logic [1:0] ext_len(input logic [2:0] sp);
    logic [1:0] len;
    len = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (!sp[i]) len = 2'(i + 1);
    end
    return len;
  endfunction

endpackage

// File: rtl/fdd_ifs.sv
// Valid/ready channel interfaces for the directory byte input and the result output.
// Depends on nothing.
interface fdd_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] dir_byte;
  modport source (output valid, restart, dir_byte, input ready);
  modport sink   (input valid, restart, dir_byte, output ready);
endinterface

interface fdd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [7:0]  name_pos;
  logic        is_directory;
  logic [31:0] first_cluster;
  logic [31:0] file_size;
  logic        last;
  modport source (output valid, kind, name_char, name_pos, is_directory,
                  first_cluster, file_size, last, input ready);
  modport sink   (input valid, kind, name_char, name_pos, is_directory,
                  first_cluster, file_size, last, output ready);
endinterface

// File: rtl/fat_dir_entry_decoder.sv
// Top level of the FAT directory entry decoder: byte intake, entry store and
// result sequencer. Depends on fdd_pkg, fdd_ifs, fdd_entry_buf, fdd_emit_seq.
//
//  channel   dir   handshake            payload
//  in_ch     in    valid/ready          restart, dir_byte
//  out_ch    out   valid/ready          kind, name_char, name_pos, is_directory,
//                                       first_cluster, file_size, last
//
// Cycles: a byte that does not complete an entry is taken every cycle.
// The byte that completes an entry (or an end marker) is registered as a go flag
// that the idle sequencer decides on; then it gives one result per transfer, set by
// the single read port of the entry store that it walks one character a cycle unless out_ch stalls.
// in_ch.ready stays low from that byte until the last result is in the output
// register; a stall on out_ch stretches this by the stalled cycles.
// Reset (rst_n low, synchronous) clears byte position, end flag and the
// sequencer; the entry store is not cleared.
module fat_dir_entry_decoder
  import fdd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fdd_in_if.sink    in_ch,
  fdd_out_if.source out_ch
);

  logic [ADDR_W-1:0] byte_pos_r, byte_pos_nxt;
  logic              ended_r, ended_nxt;
  go_t               go_r, go_nxt;

  logic              seq_idle;
  logic              in_xfer;
  logic [ADDR_W-1:0] eff_pos;
  logic              eff_ended;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  entry_info_t       info;

  // Hold off new bytes while an entry is being decided or emitted
  assign in_ch.ready = seq_idle && !go_r.valid;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Restart applies before the byte itself is looked at
  assign eff_pos   = in_ch.restart ? '0 : byte_pos_r;
  assign eff_ended = in_ch.restart ? 1'b0 : ended_r;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    ended_nxt    = ended_r;
    go_nxt       = '0;
    wr_en        = 1'b0;
    if (in_xfer) begin
      byte_pos_nxt = eff_pos;
      ended_nxt    = eff_ended;
      if (!eff_ended) begin
        if (eff_pos == '0 && in_ch.dir_byte == CHAR_NUL) begin
          // end of directory: one end result, then drop bytes until restart
          ended_nxt  = 1'b1;
          go_nxt     = '{valid: 1'b1, eod: 1'b1};
        end else begin
          wr_en        = 1'b1;
          byte_pos_nxt = eff_pos + 1'b1;  // wraps to zero after the last byte
          if (eff_pos == ADDR_W'(ENTRY_LEN - 1)) begin
            go_nxt = '{valid: 1'b1, eod: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      ended_r    <= 1'b0;
      go_r       <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      ended_r    <= ended_nxt;
      go_r       <= go_nxt;
    end
  end

  fdd_entry_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (eff_pos),
    .wr_data (in_ch.dir_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .info    (info)
  );

  fdd_emit_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .info    (info),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .idle    (seq_idle),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/fdd_entry_buf.sv
// 32-byte entry store: one write port, one indexed read, fixed-field taps.
// Depends on fdd_pkg.
module fdd_entry_buf
  import fdd_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output entry_info_t       info
);

  logic [7:0] mem_r [ENTRY_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  assign rd_data = mem_r[rd_addr];

  always_comb begin
    info.first   = mem_r[0];
    info.attr    = mem_r[OFS_ATTR];
    info.cluster = {mem_r[OFS_CLUS_HI + 5'd1], mem_r[OFS_CLUS_HI],
                    mem_r[OFS_CLUS_LO + 5'd1], mem_r[OFS_CLUS_LO]};
    info.size    = {mem_r[OFS_SIZE + 5'd3], mem_r[OFS_SIZE + 5'd2],
                    mem_r[OFS_SIZE + 5'd1], mem_r[OFS_SIZE]};
    for (int i = 0; i < 11; i++) begin
      info.space_mask[i] = (mem_r[i] == CHAR_SPACE);
    end
  end

endmodule

// File: rtl/fdd_emit_seq.sv
// Result sequencer: steps one read port and one position counter over the
// characters of a decoded entry, one result per transfer. Depends on fdd_pkg.
module fdd_emit_seq
  import fdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  go_t               go,
  input  entry_info_t       info,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              idle,
  fdd_out_if.source         out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_END, S_LFN, S_NAME, S_DOT, S_EXT, S_NUL
  } state_t;

  state_t      state_r;
  logic [3:0]  k_r;
  logic [7:0]  pos_r;
  logic [3:0]  nlen_r;
  logic [1:0]  elen_r;
  logic        last_seg_r;
  logic        short_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  char_r;
  logic [7:0]  name_pos_r;
  logic        dir_r;
  logic [31:0] clus_r;
  logic [31:0] size_r;
  logic        last_r;

  logic        adv;
  logic [4:0]  seg_raw;
  logic [4:0]  seg;
  logic [3:0]  nlen;
  logic [1:0]  elen;

  assign adv     = !out_valid_r || out_ch.ready;
  assign idle    = (state_r == S_IDLE);
  assign seg_raw = info.first[4:0];
  assign seg     = seg_raw - 5'd1;
  assign nlen    = name_len(info.space_mask[7:0]);
  assign elen    = ext_len(info.space_mask[10:8]);

  always_comb begin
    unique case (state_r)
      S_LFN:   rd_addr = lfn_offset(k_r);
      S_EXT:   rd_addr = OFS_EXT + {1'b0, k_r};
      default: rd_addr = {1'b0, k_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // drop the last result once it has been taken
          if (adv) out_valid_r <= 1'b0;
          if (go.valid) begin
            k_r <= 4'd0;
            if (go.eod) begin
              state_r <= S_END;
            end else if (info.first == DELETED_MARK) begin
              state_r <= S_IDLE;
            end else if (info.attr == ATTR_LFN) begin
              short_r    <= 1'b0;
              last_seg_r <= (seg_raw == SEG_RAW_LAST);
              pos_r      <= 8'(seg) * LFN_CHARS;
              // drop segments outside the valid range
              if (seg_raw != 5'd0 && seg_raw <= SEG_RAW_LAST) state_r <= S_LFN;
            end else begin
              short_r <= 1'b1;
              pos_r   <= 8'd0;
              nlen_r  <= nlen;
              elen_r  <= elen;
              priority if (nlen != 4'd0) state_r <= S_NAME;
              else if (elen != 2'd0)     state_r <= S_DOT;
              else                       state_r <= S_NUL;
            end
          end
        end
        S_END: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_END;
            char_r      <= CHAR_NUL;
            name_pos_r  <= 8'd0;
            dir_r       <= 1'b0;
            clus_r      <= 32'd0;
            size_r      <= 32'd0;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_LFN: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_LFN;
            char_r      <= rd_data;
            name_pos_r  <= pos_r;
            dir_r       <= 1'b0;
            clus_r      <= 32'd0;
            size_r      <= 32'd0;
            last_r      <= (k_r == LFN_LAST_K);
            pos_r       <= pos_r + 8'd1;
            k_r         <= k_r + 4'd1;
            priority if (last_seg_r && k_r == LFN_TAIL_K) begin
              state_r <= S_NUL;
            end else if (k_r == LFN_LAST_K) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_NAME: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_SHORT;
            char_r      <= rd_data;
            name_pos_r  <= pos_r;
            dir_r       <= info.attr[ATTR_DIR_BIT];
            clus_r      <= info.cluster;
            size_r      <= info.size;
            last_r      <= 1'b0;
            pos_r       <= pos_r + 8'd1;
            k_r         <= k_r + 4'd1;
            if ((k_r + 4'd1) == nlen_r) begin
              state_r <= (elen_r != 2'd0) ? S_DOT : S_NUL;
            end
          end
        end
        S_DOT: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_SHORT;
            char_r      <= CHAR_DOT;
            name_pos_r  <= pos_r;
            dir_r       <= info.attr[ATTR_DIR_BIT];
            clus_r      <= info.cluster;
            size_r      <= info.size;
            last_r      <= 1'b0;
            pos_r       <= pos_r + 8'd1;
            k_r         <= 4'd0;
            state_r     <= S_EXT;
          end
        end
        S_EXT: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_SHORT;
            char_r      <= rd_data;
            name_pos_r  <= pos_r;
            dir_r       <= info.attr[ATTR_DIR_BIT];
            clus_r      <= info.cluster;
            size_r      <= info.size;
            last_r      <= 1'b0;
            pos_r       <= pos_r + 8'd1;
            k_r         <= k_r + 4'd1;
            if ((k_r[1:0] + 2'd1) == elen_r) state_r <= S_NUL;
          end
        end
        S_NUL: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            kind_r      <= short_r ? KIND_SHORT : KIND_LFN;
            char_r      <= CHAR_NUL;
            name_pos_r  <= pos_r;
            dir_r       <= short_r & info.attr[ATTR_DIR_BIT];
            clus_r      <= short_r ? info.cluster : 32'd0;
            size_r      <= short_r ? info.size : 32'd0;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.name_char     = char_r;
  assign out_ch.name_pos      = name_pos_r;
  assign out_ch.is_directory  = dir_r;
  assign out_ch.first_cluster = clus_r;
  assign out_ch.file_size     = size_r;
  assign out_ch.last          = last_r;

endmodule
